// ----- sv/nearest_palette_color_search_assert.svh -----
// Assertion macros shared by the nearest palette color search design.
`ifndef NEAREST_PALETTE_COLOR_SEARCH_ASSERT_SVH
`define NEAREST_PALETTE_COLOR_SEARCH_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NPCS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define NPCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- sv/npcs_pkg.sv -----
// Package with the shared types and constants of the palette search block.
package npcs_pkg;

    // Field widths.
    localparam int COMP_W  = 8;
    localparam int IDX_W   = 8;
    localparam int COUNT_W = 9;
    localparam int SQ_W    = 16;
    localparam int DIST_W  = 18;

    // Command codes of an input transaction.
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Starting best distance; larger than any real distance (3 * 255 * 255).
    localparam logic [DIST_W-1:0] DIST_INIT = '1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_wr;
        logic query_start;
        logic rd_issue;
        logic result_load;
    } npcs_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pipe_busy;
        logic exact_hit;
    } npcs_status_t;

endpackage

// ----- sv/npcs_if.sv -----
// Channel interfaces for the input and result transactions.
interface npcs_req_if;
    logic                          valid;
    logic                          ready;
    logic                          command;
    logic [npcs_pkg::IDX_W-1:0]    entry_index;
    logic [npcs_pkg::COMP_W-1:0]   red;
    logic [npcs_pkg::COMP_W-1:0]   green;
    logic [npcs_pkg::COMP_W-1:0]   blue;

    modport source (output valid, command, entry_index, red, green, blue, input ready);
    modport sink (input valid, command, entry_index, red, green, blue, output ready);
endinterface

interface npcs_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [npcs_pkg::IDX_W-1:0]    closest_index;

    modport source (output valid, closest_index, input ready);
    modport sink (input valid, closest_index, output ready);
endinterface

// ----- sv/npcs_ctrl.sv -----
// Controller state machine that sequences loads, palette scans and results.
module npcs_ctrl #(
    parameter int PALETTE_DEPTH = 256,
    parameter int ADDR_W        = 8,
    parameter int CNT_W         = 9
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_ready,
    input  logic                            req_command,
    input  logic [npcs_pkg::IDX_W-1:0]      req_entry_index,
    output logic                            rsp_valid,
    input  logic                            rsp_ready,
    input  logic                            cfg_wr_en,
    input  logic [npcs_pkg::COUNT_W-1:0]    cfg_wr_data,
    output npcs_pkg::npcs_cmd_t             cmd,
    input  npcs_pkg::npcs_status_t          status,
    output logic [ADDR_W-1:0]               wr_addr,
    output logic [ADDR_W-1:0]               rd_addr
);

    localparam int XW = (CNT_W > npcs_pkg::COUNT_W) ? CNT_W : npcs_pkg::COUNT_W;
    localparam int EW = (CNT_W > npcs_pkg::IDX_W) ? CNT_W : npcs_pkg::IDX_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } state_t;

    state_t                          state_reg, state_next;
    logic [CNT_W-1:0]                scan_reg, scan_next;
    logic [CNT_W-1:0]                count_reg, count_next;
    logic                            out_valid_reg, out_valid_next;
    logic [npcs_pkg::COUNT_W-1:0]    palette_count_reg, palette_count_next;

    logic [CNT_W-1:0]                count_sat;
    logic                            scan_last;
    logic                            slot_in_range;

    // Effective count is the register saturated to the palette depth.
    always_comb
    begin
        if (XW'(palette_count_reg) > XW'(PALETTE_DEPTH))
        begin
            count_sat = CNT_W'(PALETTE_DEPTH);
        end
        else
        begin
            count_sat = CNT_W'(palette_count_reg);
        end
    end

    assign scan_last     = (CNT_W'(scan_reg + 1'b1) == count_reg);
    assign slot_in_range = (EW'(req_entry_index) < EW'(PALETTE_DEPTH));
    assign wr_addr       = ADDR_W'(req_entry_index);
    assign rd_addr       = scan_reg[ADDR_W-1:0];
    assign req_ready     = (state_reg == ST_IDLE);
    assign rsp_valid     = out_valid_reg;

    // Next-state and command decode.
    always_comb
    begin
        state_next         = state_reg;
        scan_next          = scan_reg;
        count_next         = count_reg;
        out_valid_next     = out_valid_reg;
        palette_count_next = palette_count_reg;
        cmd                = '0;

        if (cfg_wr_en)
        begin
            palette_count_next = cfg_wr_data;
        end

        if (out_valid_reg && rsp_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    if (req_command == npcs_pkg::CMD_LOAD)
                    begin
                        cmd.load_wr = slot_in_range;
                    end
                    else
                    begin
                        cmd.query_start = 1'b1;
                        count_next      = count_sat;
                        scan_next       = '0;
                        state_next      = (count_sat == '0) ? ST_DRAIN : ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                // One palette read per cycle; stop at the last entry or an exact match.
                cmd.rd_issue = 1'b1;
                if (scan_last || status.exact_hit)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    scan_next = CNT_W'(scan_reg + 1'b1);
                end
            end
            ST_DRAIN:
            begin
                // Wait for the pipeline to empty and the result slot to free up.
                if (!status.pipe_busy && (!out_valid_reg || rsp_ready))
                begin
                    cmd.result_load = 1'b1;
                    out_valid_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            scan_reg          <= '0;
            count_reg         <= '0;
            out_valid_reg     <= 1'b0;
            palette_count_reg <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            scan_reg          <= scan_next;
            count_reg         <= count_next;
            out_valid_reg     <= out_valid_next;
            palette_count_reg <= palette_count_next;
        end
    end

endmodule

// ----- sv/npcs_datapath.sv -----
// Datapath with the palette memory, the distance pipeline and the best-match tracker.
module npcs_datapath #(
    parameter int PALETTE_DEPTH = 256,
    parameter int ADDR_W        = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  npcs_pkg::npcs_cmd_t             cmd,
    output npcs_pkg::npcs_status_t          status,
    input  logic [ADDR_W-1:0]               wr_addr,
    input  logic [ADDR_W-1:0]               rd_addr,
    input  logic [npcs_pkg::COMP_W-1:0]     red,
    input  logic [npcs_pkg::COMP_W-1:0]     green,
    input  logic [npcs_pkg::COMP_W-1:0]     blue,
    output logic [npcs_pkg::IDX_W-1:0]      closest_index
);

    localparam int CW = npcs_pkg::COMP_W;
    localparam int OW = (ADDR_W > npcs_pkg::IDX_W) ? ADDR_W : npcs_pkg::IDX_W;

    logic [3*CW-1:0]                 palette_mem [PALETTE_DEPTH];

    logic [CW-1:0]                   q_red_reg, q_green_reg, q_blue_reg;
    logic [3*CW-1:0]                 rd_data_reg;
    logic [ADDR_W-1:0]               idx1_reg, idx2_reg;
    logic                            v1_reg, v2_reg;
    logic [npcs_pkg::SQ_W-1:0]       sq_r_reg, sq_g_reg, sq_b_reg;
    logic [npcs_pkg::DIST_W-1:0]     best_dist_reg, best_dist_next;
    logic [ADDR_W-1:0]               best_idx_reg, best_idx_next;
    logic                            hit_reg, hit_next;
    logic [npcs_pkg::IDX_W-1:0]      closest_reg;

    logic [CW-1:0]                   diff_r, diff_g, diff_b;
    logic [npcs_pkg::DIST_W-1:0]     dist_sum;
    logic                            take;
    logic [OW-1:0]                   best_ext;

    // Palette memory: one write port for loads, one registered read port for scans.
    always_ff @(posedge clk)
    begin
        if (cmd.load_wr)
        begin
            palette_mem[wr_addr] <= {red, green, blue};
        end
        if (cmd.rd_issue)
        begin
            rd_data_reg <= palette_mem[rd_addr];
        end
    end

    // Query color and entry index tags along the pipeline.
    always_ff @(posedge clk)
    begin
        if (cmd.query_start)
        begin
            q_red_reg   <= red;
            q_green_reg <= green;
            q_blue_reg  <= blue;
        end
        idx1_reg <= rd_addr;
        idx2_reg <= idx1_reg;
    end

    // Absolute component differences against the query color.
    always_comb
    begin
        diff_r = (rd_data_reg[3*CW-1:2*CW] > q_red_reg) ?
                 rd_data_reg[3*CW-1:2*CW] - q_red_reg : q_red_reg - rd_data_reg[3*CW-1:2*CW];
        diff_g = (rd_data_reg[2*CW-1:CW] > q_green_reg) ?
                 rd_data_reg[2*CW-1:CW] - q_green_reg : q_green_reg - rd_data_reg[2*CW-1:CW];
        diff_b = (rd_data_reg[CW-1:0] > q_blue_reg) ?
                 rd_data_reg[CW-1:0] - q_blue_reg : q_blue_reg - rd_data_reg[CW-1:0];
    end

    // Squares stage.
    always_ff @(posedge clk)
    begin
        sq_r_reg <= npcs_pkg::SQ_W'(diff_r) * npcs_pkg::SQ_W'(diff_r);
        sq_g_reg <= npcs_pkg::SQ_W'(diff_g) * npcs_pkg::SQ_W'(diff_g);
        sq_b_reg <= npcs_pkg::SQ_W'(diff_b) * npcs_pkg::SQ_W'(diff_b);
    end

    // Sum and strict compare; only a strictly smaller distance replaces the best.
    always_comb
    begin
        dist_sum = npcs_pkg::DIST_W'(sq_r_reg) + npcs_pkg::DIST_W'(sq_g_reg)
                 + npcs_pkg::DIST_W'(sq_b_reg);
        take           = v2_reg && (dist_sum < best_dist_reg);
        best_dist_next = best_dist_reg;
        best_idx_next  = best_idx_reg;
        hit_next       = hit_reg;
        if (cmd.query_start)
        begin
            best_dist_next = npcs_pkg::DIST_INIT;
            best_idx_next  = '0;
            hit_next       = 1'b0;
        end
        else if (take)
        begin
            best_dist_next = dist_sum;
            best_idx_next  = idx2_reg;
            hit_next       = (dist_sum == '0);
        end
    end

    // Best match and result register.
    always_ff @(posedge clk)
    begin
        best_dist_reg <= best_dist_next;
        best_idx_reg  <= best_idx_next;
        if (cmd.result_load)
        begin
            closest_reg <= best_ext[npcs_pkg::IDX_W-1:0];
        end
    end

    // Pipeline valid bits and the exact-match flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            hit_reg <= 1'b0;
        end
        else
        begin
            v1_reg  <= cmd.rd_issue;
            v2_reg  <= v1_reg;
            hit_reg <= hit_next;
        end
    end

    assign best_ext         = OW'(best_idx_reg);
    assign status.pipe_busy = v1_reg || v2_reg;
    assign status.exact_hit = hit_reg;
    assign closest_index    = closest_reg;

endmodule

// ----- sv/nearest_palette_color_search.sv -----
// Top level of the nearest palette color search block.
//
// Channel   Modport   Fields                                   Role
// req       sink      command, entry_index, red, green, blue  palette load or color query
// rsp       source    closest_index                           index of the nearest entry
// cfg       write     cfg_wr_en, cfg_wr_data                  palette_count register
//
// A load gives no result.
// A query reads one palette entry per cycle from the single read port, then the
// three-stage distance pipeline drains. The scan reads palette_count entries,
// saturated to PALETTE_DEPTH, fewer on an exact match, none for an empty palette.
// Reset clears control state only; palette contents are undefined until loaded.
// A waiting result lets loads through but holds the next query result until taken.
module nearest_palette_color_search #(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    npcs_req_if.sink                        req,
    npcs_rsp_if.source                      rsp,
    input  logic                            cfg_wr_en,
    input  logic [npcs_pkg::COUNT_W-1:0]    cfg_wr_data
);

    `include "nearest_palette_color_search_assert.svh"

    localparam int ADDR_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(PALETTE_DEPTH + 1);

    npcs_pkg::npcs_cmd_t       cmd;
    npcs_pkg::npcs_status_t    status;
    logic [ADDR_W-1:0]         wr_addr;
    logic [ADDR_W-1:0]         rd_addr;

    // Controller.
    npcs_ctrl #(
        .PALETTE_DEPTH (PALETTE_DEPTH),
        .ADDR_W        (ADDR_W),
        .CNT_W         (CNT_W)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req.valid),
        .req_ready       (req.ready),
        .req_command     (req.command),
        .req_entry_index (req.entry_index),
        .rsp_valid       (rsp.valid),
        .rsp_ready       (rsp.ready),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .cmd             (cmd),
        .status          (status),
        .wr_addr         (wr_addr),
        .rd_addr         (rd_addr)
    );

    // Datapath.
    npcs_datapath #(
        .PALETTE_DEPTH (PALETTE_DEPTH),
        .ADDR_W        (ADDR_W)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .wr_addr       (wr_addr),
        .rd_addr       (rd_addr),
        .red           (req.red),
        .green         (req.green),
        .blue          (req.blue),
        .closest_index (rsp.closest_index)
    );

    // The block takes a transaction only with an empty distance pipeline.
    `NPCS_ASSERT_SAME(a_idle_pipe_empty, clk, rst_n, req.ready, !status.pipe_busy)
    // A result is captured only after the last compare has retired.
    `NPCS_ASSERT_SAME(a_result_after_drain, clk, rst_n, cmd.result_load, !status.pipe_busy)
    // A captured result is presented on the next cycle.
    `NPCS_ASSERT_NEXT(a_result_presented, clk, rst_n, cmd.result_load, rsp.valid)
    // A palette write comes only from an accepted load transaction.
    `NPCS_ASSERT_SAME(a_write_from_load, clk, rst_n, cmd.load_wr,
        req.valid && req.ready && (req.command == npcs_pkg::CMD_LOAD))

endmodule

// ----- tb/nearest_palette_color_search_tb.sv -----
// Self-checking testbench for the nearest palette color search block.
`timescale 1ns / 1ps

module nearest_palette_color_search_tb;

    localparam int PALETTE_SLOTS = 256;
    localparam int RESET_CYCLES  = 6;
    // Cycles left after the last result so that a trailing palette load completes.
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_CYCLES   = 600;
    localparam int PHASE_ITEMS   = 75;
    localparam int CYCLE_LIMIT   = 1_000_000;

    typedef struct packed {
        logic                          command;
        logic [npcs_pkg::IDX_W-1:0]    entry_index;
        logic [npcs_pkg::COMP_W-1:0]   red;
        logic [npcs_pkg::COMP_W-1:0]   green;
        logic [npcs_pkg::COMP_W-1:0]   blue;
    } palette_item_t;

    // Predicts the closest palette entry for each query and matches it to the block.
    class palette_scoreboard;
        logic [3*npcs_pkg::COMP_W-1:0] palette_mem [PALETTE_SLOTS];
        logic [npcs_pkg::COUNT_W-1:0]  palette_count;
        logic [npcs_pkg::IDX_W-1:0]    expected_index_q [$];
        int                            mismatches;
        int                            load_total;
        int                            query_total;
        int                            result_total;

        function new();
            foreach (palette_mem[i])
            begin
                palette_mem[i] = '0;
            end
            palette_count = '0;
            mismatches    = 0;
            load_total    = 0;
            query_total   = 0;
            result_total  = 0;
        endfunction

        function void set_count(logic [npcs_pkg::COUNT_W-1:0] value);
            palette_count = value;
        endfunction

        function int pending();
            return expected_index_q.size();
        endfunction

        // First entry with the strictly smallest squared distance; stops on an exact hit.
        function logic [npcs_pkg::IDX_W-1:0] nearest_entry(logic [npcs_pkg::COMP_W-1:0] r,
                                                           logic [npcs_pkg::COMP_W-1:0] g,
                                                           logic [npcs_pkg::COMP_W-1:0] b);
            int unsigned                span;
            int unsigned                best_dist;
            int unsigned                sq_dist;
            int                         dr;
            int                         dg;
            int                         db;
            logic [npcs_pkg::IDX_W-1:0] best;
            span      = (palette_count > PALETTE_SLOTS) ? PALETTE_SLOTS : palette_count;
            best      = '0;
            best_dist = 32'h7fff_ffff;
            for (int i = 0; i < span; i++)
            begin
                dr      = int'(palette_mem[i][23:16]) - int'(r);
                dg      = int'(palette_mem[i][15:8]) - int'(g);
                db      = int'(palette_mem[i][7:0]) - int'(b);
                sq_dist = dr * dr + dg * dg + db * db;
                if (sq_dist < best_dist)
                begin
                    best_dist = sq_dist;
                    best      = npcs_pkg::IDX_W'(i);
                    if (sq_dist == 0)
                        break;
                end
            end
            return best;
        endfunction

        function void note_transaction(palette_item_t item);
            if (item.command == npcs_pkg::CMD_LOAD)
            begin
                palette_mem[item.entry_index] = {item.red, item.green, item.blue};
                load_total++;
            end
            else
            begin
                expected_index_q.push_back(nearest_entry(item.red, item.green, item.blue));
                query_total++;
            end
        endfunction

        task report_mismatch(string what);
            $display("ERROR at %0t: %s", $realtime, what);
            mismatches++;
        endtask

        task check_result(logic [npcs_pkg::IDX_W-1:0] got);
            logic [npcs_pkg::IDX_W-1:0] want;
            result_total++;
            if (expected_index_q.size() == 0)
            begin
                report_mismatch($sformatf("closest_index %0d arrived with no query outstanding",
                                          got));
                return;
            end
            want = expected_index_q.pop_front();
            if (got !== want)
                report_mismatch($sformatf("closest_index %0d, expected %0d (result %0d)",
                                          got, want, result_total));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic [npcs_pkg::COUNT_W-1:0] cfg_wr_data;

    npcs_req_if req_ch ();
    npcs_rsp_if rsp_ch ();

    palette_scoreboard sb;
    bit   slot_written [PALETTE_SLOTS];
    int   count_setting;
    int   settings_seen;
    bit   hold_request;
    bit   no_idle;
    int   cycle_count;

    // Colors that recur often so that duplicate entries and distance ties show up.
    localparam logic [23:0] SWATCHES [8] = '{24'h000000, 24'hffffff, 24'hff0000, 24'h00ff00,
                                            24'h0000ff, 24'h808080, 24'h7f7f7f, 24'hff00ff};

    nearest_palette_color_search u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #5 clk = ~clk;

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("nearest_palette_color_search: mismatch");
            $finish;
        end
    end

    // Every accepted result transaction is checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            sb.check_result(rsp_ch.closest_index);
    end

    // Result side: random stalls, one long hold-off on request, none at the end.
    initial
    begin
        rsp_ch.ready <= 1'b0;
        do
            @(posedge clk);
        while (rst_n !== 1'b1);
        forever
        begin
            if (hold_request)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            else if (!no_idle && $urandom_range(0, 3) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge clk);
            end
        end
    end

    function automatic palette_item_t make_item(logic cmd, logic [npcs_pkg::IDX_W-1:0] slot,
                                                logic [23:0] color);
        palette_item_t item;
        item.command     = cmd;
        item.entry_index = slot;
        item.red         = color[23:16];
        item.green       = color[15:8];
        item.blue        = color[7:0];
        return item;
    endfunction

    function automatic logic [23:0] pick_palette_color();
        if ($urandom_range(0, 9) < 3)
            return SWATCHES[$urandom_range(0, 7)];
        return 24'($urandom);
    endfunction

    function automatic logic [npcs_pkg::COMP_W-1:0] nudge(logic [npcs_pkg::COMP_W-1:0] c);
        int v;
        v = int'(c) + int'($urandom_range(0, 6)) - 3;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return npcs_pkg::COMP_W'(v);
    endfunction

    // Query colors: exact copies of searched entries, near misses, random and corner colors.
    function automatic logic [23:0] pick_query_color(int span);
        int          mode;
        logic [23:0] base;
        mode = $urandom_range(0, 99);
        if (span > 0 && mode < 60)
        begin
            base = sb.palette_mem[$urandom_range(0, span - 1)];
            if (mode < 40)
                return base;
            return {nudge(base[23:16]), nudge(base[15:8]), nudge(base[7:0])};
        end
        if (mode < 90)
            return 24'($urandom);
        return {{8{1'($urandom)}}, {8{1'($urandom)}}, {8{1'($urandom)}}};
    endfunction

    // Offers one transaction and waits until the block takes it.
    task automatic send_item(palette_item_t item);
        if (!no_idle && $urandom_range(0, 4) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.command     <= item.command;
        req_ch.entry_index <= item.entry_index;
        req_ch.red         <= item.red;
        req_ch.green       <= item.green;
        req_ch.blue        <= item.blue;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        sb.note_transaction(item);
        if (item.command == npcs_pkg::CMD_LOAD)
            slot_written[item.entry_index] = 1'b1;
    endtask

    // Mostly well-formed: a query is only sent once every searched entry has been loaded.
    task automatic send_random_item();
        palette_item_t item;
        int            span;
        int            gap_slot;
        span     = (count_setting > PALETTE_SLOTS) ? PALETTE_SLOTS : count_setting;
        gap_slot = -1;
        for (int i = span - 1; i >= 0; i--)
        begin
            if (!slot_written[i])
                gap_slot = i;
        end
        if ($urandom_range(0, 99) < 55)
        begin
            if (gap_slot >= 0)
                item = make_item(npcs_pkg::CMD_LOAD, npcs_pkg::IDX_W'(gap_slot),
                                 pick_palette_color());
            else
                item = make_item(npcs_pkg::CMD_QUERY, npcs_pkg::IDX_W'($urandom),
                                 pick_query_color(span));
        end
        else if (span > 0 && $urandom_range(0, 1) == 1)
            item = make_item(npcs_pkg::CMD_LOAD, npcs_pkg::IDX_W'($urandom_range(0, span - 1)),
                             pick_palette_color());
        else
            item = make_item(npcs_pkg::CMD_LOAD, npcs_pkg::IDX_W'($urandom),
                             pick_palette_color());
        send_item(item);
    endtask

    // Stops offering, waits for every outstanding result and lets a trailing load finish.
    task automatic settle();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_count(int value);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= npcs_pkg::COUNT_W'(value);
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.set_count(npcs_pkg::COUNT_W'(value));
        count_setting = value;
        settings_seen++;
    endtask

    // Count settings of the random phases; large ones are kept few.
    int phase_counts [16] = '{5, 1, 16, 256, 3, 511, 0, 32, 8, 257, 2, 24, 255, 12, 7, 20};

    initial
    begin
        sb            = new();
        count_setting = 0;
        settings_seen = 0;
        hold_request  = 1'b0;
        no_idle       = 1'b0;
        cycle_count   = 0;
        foreach (slot_written[i])
        begin
            slot_written[i] = 1'b0;
        end
        rst_n              <= 1'b0;
        cfg_wr_en          <= 1'b0;
        cfg_wr_data        <= '0;
        req_ch.valid       <= 1'b0;
        req_ch.command     <= npcs_pkg::CMD_LOAD;
        req_ch.entry_index <= '0;
        req_ch.red         <= '0;
        req_ch.green       <= '0;
        req_ch.blue        <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Empty palette right after reset: any query answers entry 0.
        send_item(make_item(npcs_pkg::CMD_QUERY, 8'h00, 24'h000000));
        send_item(make_item(npcs_pkg::CMD_QUERY, 8'hff, 24'hffffff));

        // Palette with duplicates at both color extremes, plus the top slot.
        send_item(make_item(npcs_pkg::CMD_LOAD, 8'd0, 24'h000000));
        send_item(make_item(npcs_pkg::CMD_LOAD, 8'd1, 24'hffffff));
        send_item(make_item(npcs_pkg::CMD_LOAD, 8'd2, 24'h000000));
        send_item(make_item(npcs_pkg::CMD_LOAD, 8'd3, 24'h808080));
        send_item(make_item(npcs_pkg::CMD_LOAD, 8'd4, 24'hffffff));
        send_item(make_item(npcs_pkg::CMD_LOAD, 8'd255, 24'hff00ff));

        // A single searched entry wins regardless of distance.
        write_count(1);
        send_item(make_item(npcs_pkg::CMD_QUERY, 8'd0, 24'hffffff));
        send_item(make_item(npcs_pkg::CMD_QUERY, 8'd7, 24'h000000));

        // Exact hits, first-of-duplicates, nearest miss and an equal-distance tie.
        write_count(5);
        send_item(make_item(npcs_pkg::CMD_QUERY, 8'd0, 24'h000000));
        send_item(make_item(npcs_pkg::CMD_QUERY, 8'd0, 24'hffffff));
        send_item(make_item(npcs_pkg::CMD_QUERY, 8'd0, 24'h808080));
        send_item(make_item(npcs_pkg::CMD_QUERY, 8'd0, 24'h7f7f7f));
        send_item(make_item(npcs_pkg::CMD_QUERY, 8'd0, 24'h404040));
        send_item(make_item(npcs_pkg::CMD_QUERY, 8'haa, 24'hc80a5a));
        send_item(make_item(npcs_pkg::CMD_QUERY, 8'h55, 24'hff00ff));

        // Random phases over a range of counts, including zero and saturated values.
        for (int p = 0; p < 16; p++)
        begin
            write_count(phase_counts[p]);
            if (p == 2)
                hold_request = 1'b1;
            if (p == 15)
                no_idle = 1'b1;
            repeat (PHASE_ITEMS) send_random_item();
        end

        settle();
        $display("Run covered %0d palette loads and %0d color queries (%0d results checked)",
                 sb.load_total, sb.query_total, sb.result_total);
        $display("over %0d palette_count settings, empty to saturated, with stalls both sides",
                 settings_seen);
        if (sb.mismatches == 0)
            $display("nearest_palette_color_search: match");
        else
            $display("nearest_palette_color_search: mismatch");
        $finish;
    end

endmodule

// ----- nearest_palette_color_search.f -----
+incdir+sv
sv/npcs_pkg.sv
sv/npcs_if.sv
sv/npcs_ctrl.sv
sv/npcs_datapath.sv
sv/nearest_palette_color_search.sv
tb/nearest_palette_color_search_tb.sv
